// ===== src/event_rate_meter_ema_top_assert.svh =====
// Assertion macros for the event rate meter top level.
`ifndef EVENT_RATE_METER_EMA_TOP_ASSERT_SVH
`define EVENT_RATE_METER_EMA_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define ERM_ASSERT_IMPLY(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("event rate meter: implication check failed");
`define ERM_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("event rate meter: next-cycle check failed");
`else
`define ERM_ASSERT_IMPLY(label, pre, post)
`define ERM_ASSERT_NEXT(label, pre, post)
`endif
`endif

// ===== src/erm_pkg.sv =====
// Shared types and constants of the event rate meter.
`timescale 1ns / 1ps
`default_nettype none
package erm_pkg;

	localparam int STAMP_WIDTH = 32;
	localparam int RATE_FRAC_BITS_DEF = 8;
	localparam int COUNT_WIDTH_DEF = 16;

	localparam logic [31:0] STAMP_MASK = (STAMP_WIDTH >= 32) ? 32'hFFFF_FFFF :
		32'((64'd1 << STAMP_WIDTH) - 64'd1);

	localparam logic [31:0] EVAL_INTERVAL_RST = 32'd300000;
	localparam logic [31:0] UNITS_PER_SECOND_RST = 32'd1000000;

	localparam logic [1:0] OP_TICK = 2'd0;
	localparam logic [1:0] OP_START = 2'd1;
	localparam logic [1:0] OP_STOP = 2'd2;
	localparam logic [1:0] OP_CLEAR = 2'd3;

	localparam logic REG_EVAL_INTERVAL = 1'b0;
	localparam logic REG_UNITS_PER_SECOND = 1'b1;

	typedef struct packed {
		logic [1:0] operation;
		logic [31:0] timestamp;
	} op_word_t;

	typedef struct packed {
		logic [31:0] elapsed;
		logic [47:0] total_time;
		logic [31:0] rate_estimate;
		logic is_running;
	} res_word_t;

	typedef struct packed {
		logic busy;
		logic done;
	} rate_stat_t;

endpackage
`default_nettype wire

// ===== src/event_rate_meter_ema_top.sv =====
// Top level of the event rate meter with moving-average rate estimate.
// A start, clear or idle tick passes through the update and emit states; an armed tick also
// passes the check state, and the wait and finish states when it runs the multiply and divide.
// One word is handled at a time; the input accepts again once the result registers,
// and a stalled result holds input.
// Reset clears measurements and loads the register defaults (window 300000, 1000000/s).
`timescale 1ns / 1ps
`default_nettype none
`include "event_rate_meter_ema_top_assert.svh"
module event_rate_meter_ema_top #(
	parameter int COUNT_WIDTH = erm_pkg::COUNT_WIDTH_DEF,
	parameter int RATE_FRAC_BITS = erm_pkg::RATE_FRAC_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic op_valid,
	output logic op_stall,
	input wire erm_pkg::op_word_t op_word,
	output logic res_valid,
	input wire logic res_stall,
	output erm_pkg::res_word_t res_word,
	input wire logic cfg_we,
	input wire logic cfg_index,
	input wire logic [31:0] cfg_data
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_UPD = 3'd1;
	localparam logic [2:0] ST_CHK = 3'd2;
	localparam logic [2:0] ST_WAIT = 3'd3;
	localparam logic [2:0] ST_FIN = 3'd4;
	localparam logic [2:0] ST_EMIT = 3'd5;

	logic [2:0] state_q;
	logic armed_q;
	logic [31:0] last_stamp_q;
	logic [47:0] accum_q;
	logic [31:0] rate_q;
	logic [COUNT_WIDTH-1:0] count_q;
	logic [31:0] sum_q;
	logic [31:0] eval_q;
	logic [31:0] ups_q;
	logic out_valid_q;

	logic [1:0] op_q;
	logic [31:0] stamp_q;
	logic [31:0] delta_q;
	logic [31:0] elapsed_q;
	erm_pkg::res_word_t out_q;

	logic accept;
	logic ticking;
	logic [48:0] acc_add;
	logic [32:0] win_add;
	logic need_rate;
	logic emit_ok;
	logic [32:0] mean_add;
	logic rate_start;
	erm_pkg::rate_stat_t rstat;
	logic [31:0] win_rate;

	always_comb begin
		accept = op_valid && !op_stall;
		ticking = (op_q == erm_pkg::OP_TICK || op_q == erm_pkg::OP_STOP) && armed_q;
		acc_add = {1'b0, accum_q} + 49'(delta_q);
		win_add = {1'b0, sum_q} + {1'b0, delta_q};
		need_rate = (rate_q == 32'd0) || (eval_q <= sum_q);
		emit_ok = !out_valid_q || !res_stall;
		mean_add = {1'b0, rate_q} + {1'b0, win_rate};
		rate_start = (state_q == ST_CHK) && need_rate;
	end

	erm_rate_unit #(
		.COUNT_WIDTH(COUNT_WIDTH),
		.RATE_FRAC_BITS(RATE_FRAC_BITS)
	) u_rate (
		.clk(clk),
		.arst_n(arst_n),
		.start(rate_start),
		.count(count_q),
		.ups(ups_q),
		.sum(sum_q),
		.stat(rstat),
		.rate(win_rate)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eval_q <= erm_pkg::EVAL_INTERVAL_RST;
			ups_q <= erm_pkg::UNITS_PER_SECOND_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				erm_pkg::REG_EVAL_INTERVAL: eval_q <= cfg_data;
				erm_pkg::REG_UNITS_PER_SECOND: ups_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			armed_q <= 1'b0;
			last_stamp_q <= '0;
			accum_q <= '0;
			rate_q <= '0;
			count_q <= '0;
			sum_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_EMIT && emit_ok) begin
				out_valid_q <= 1'b1;
			end else if (!res_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					state_q <= ticking ? ST_CHK : ST_EMIT;
					case (op_q)
						erm_pkg::OP_TICK, erm_pkg::OP_STOP: begin
							if (armed_q) begin
								last_stamp_q <= stamp_q & erm_pkg::STAMP_MASK;
								accum_q <= acc_add[48] ? 48'hFFFF_FFFF_FFFF : acc_add[47:0];
								sum_q <= win_add[32] ? 32'hFFFF_FFFF : win_add[31:0];
								if (count_q != '1) begin
									count_q <= count_q + 1'b1;
								end
							end
							if (op_q == erm_pkg::OP_STOP) begin
								armed_q <= 1'b0;
							end
						end
						erm_pkg::OP_START: begin
							if (!armed_q) begin
								armed_q <= 1'b1;
								accum_q <= '0;
								last_stamp_q <= stamp_q & erm_pkg::STAMP_MASK;
							end
						end
						default: begin
							rate_q <= '0;
							accum_q <= '0;
							sum_q <= '0;
							count_q <= '0;
						end
					endcase
				end
				ST_CHK: begin
					state_q <= need_rate ? ST_WAIT : ST_EMIT;
				end
				ST_WAIT: begin
					if (rstat.done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (rate_q == 32'd0) begin
						rate_q <= win_rate;
					end else begin
						rate_q <= mean_add[32:1];
					end
					sum_q <= '0;
					count_q <= '0;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_ok) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= op_word.operation;
			stamp_q <= op_word.timestamp;
			delta_q <= (op_word.timestamp - last_stamp_q) & erm_pkg::STAMP_MASK;
		end
		if (state_q == ST_UPD) begin
			elapsed_q <= ticking ? delta_q : 32'd0;
		end
		if (state_q == ST_EMIT && emit_ok) begin
			out_q.elapsed <= elapsed_q;
			out_q.total_time <= accum_q;
			out_q.rate_estimate <= rate_q;
			out_q.is_running <= armed_q;
		end
	end

	assign op_stall = state_q != ST_IDLE;
	assign res_valid = out_valid_q;
	assign res_word = out_q;

	`ERM_ASSERT_IMPLY(a_done_in_wait, rstat.done, state_q == ST_WAIT)
	`ERM_ASSERT_IMPLY(a_busy_in_wait, rstat.busy, state_q == ST_WAIT)
	`ERM_ASSERT_IMPLY(a_load_from_emit, $rose(out_valid_q), $past(state_q) == ST_EMIT)
	`ERM_ASSERT_NEXT(a_fin_clears, state_q == ST_FIN, count_q == '0 && sum_q == '0)

endmodule
`default_nettype wire

// ===== src/erm_rate_unit.sv =====
// Bit-serial multiply and restoring divide for the window rate.
`timescale 1ns / 1ps
`default_nettype none
module erm_rate_unit #(
	parameter int COUNT_WIDTH = erm_pkg::COUNT_WIDTH_DEF,
	parameter int RATE_FRAC_BITS = erm_pkg::RATE_FRAC_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [COUNT_WIDTH-1:0] count,
	input wire logic [31:0] ups,
	input wire logic [31:0] sum,
	output erm_pkg::rate_stat_t stat,
	output logic [31:0] rate
);

	localparam int PW = COUNT_WIDTH + 32;
	localparam int NW = PW + RATE_FRAC_BITS;
	localparam int HI_W = NW - 32;
	localparam int CMPW = (HI_W > 32) ? HI_W : 32;
	localparam int ITW = $clog2(((COUNT_WIDTH > 32) ? COUNT_WIDTH : 32) + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL = 2'd1;
	localparam logic [1:0] ST_SAT = 2'd2;
	localparam logic [1:0] ST_DIV = 2'd3;

	logic [1:0] state_q;
	logic [ITW-1:0] cnt_q;
	logic done_q;
	logic [PW-1:0] acc_q;
	logic [31:0] rem_q;
	logic [31:0] dlo_q;

	logic [32:0] mul_add;
	logic [NW-1:0] dvd;
	logic [HI_W-1:0] dvd_hi;
	logic [CMPW-1:0] hi_ext;
	logic hi_sat;
	logic [32:0] trial;
	logic trial_ge;
	logic [32:0] trial_diff;

	always_comb begin
		mul_add = {1'b0, acc_q[PW-1:COUNT_WIDTH]} + (acc_q[0] ? {1'b0, ups} : 33'd0);
		dvd = NW'(acc_q) << RATE_FRAC_BITS;
		dvd_hi = dvd[NW-1:32];
		hi_ext = CMPW'(dvd_hi);
		hi_sat = hi_ext >= CMPW'(sum);
		trial = {rem_q, dlo_q[31]};
		trial_ge = trial >= {1'b0, sum};
		trial_diff = trial - {1'b0, sum};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= ((state_q == ST_SAT) && hi_sat) ||
				((state_q == ST_DIV) && (cnt_q == ITW'(31)));
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						cnt_q <= '0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == ITW'(COUNT_WIDTH - 1)) begin
						state_q <= ST_SAT;
					end
				end
				ST_SAT: begin
					cnt_q <= '0;
					if (hi_sat) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == ITW'(31)) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					acc_q <= {32'd0, count};
				end
			end
			ST_MUL: begin
				acc_q <= {mul_add, acc_q[COUNT_WIDTH-1:1]};
			end
			ST_SAT: begin
				if (hi_sat) begin
					dlo_q <= 32'hFFFF_FFFF;
				end else begin
					rem_q <= hi_ext[31:0];
					dlo_q <= dvd[31:0];
				end
			end
			ST_DIV: begin
				if (trial_ge) begin
					rem_q <= trial_diff[31:0];
				end else begin
					rem_q <= trial[31:0];
				end
				dlo_q <= {dlo_q[30:0], trial_ge};
			end
			default: begin
			end
		endcase
	end

	assign stat.busy = state_q != ST_IDLE;
	assign stat.done = done_q;
	assign rate = dlo_q;

endmodule
`default_nettype wire
